/* rtl/core/cmrb_pkg.sv */
// ----------------------------------------------------------------------------
// cmrb_pkg
// Shared types and constants of the cartridge mapper RAM bank controller.
// ----------------------------------------------------------------------------
`default_nettype none

package cmrb_pkg;

    localparam int unsigned RAM_DEPTH = 512;
    localparam int unsigned RAM_AW    = $clog2(RAM_DEPTH);
    localparam int unsigned NIB_W     = 4;

    localparam logic [15:0] ENABLE_TOP  = 16'h1FFF;
    localparam logic [15:0] BANK_LOW    = 16'h2000;
    localparam logic [15:0] BANK_TOP    = 16'h3FFF;
    localparam logic [15:0] WINDOW_BASE = 16'hA000;
    localparam logic [15:0] WINDOW_TOP  = 16'hA1FF;
    localparam int unsigned ADDR_SEL_BIT = 8;

    localparam logic [7:0]       ENABLE_MASK = 8'h0A;
    localparam logic [NIB_W-1:0] BANK_RESET  = 4'h1;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef struct packed {
        logic enable_wr;
        logic bank_wr;
        logic win_wr;
        logic win_rd;
        logic handled;
    } decode_t;

endpackage

`default_nettype wire

/* rtl/core/cmrb_decode.sv */
// ----------------------------------------------------------------------------
// cmrb_decode
// Address and access-kind decode of one bus item into region hits.
// ----------------------------------------------------------------------------
`default_nettype none

module cmrb_decode (
    input  wire logic          action,
    input  wire logic [15:0]   address,
    output cmrb_pkg::decode_t  dec
);
    import cmrb_pkg::*;

    logic is_wr;
    logic sel_bit;
    logic in_enable;
    logic in_bank;
    logic in_win;

    always_comb
    begin
        is_wr     = (action == ACT_WRITE);
        sel_bit   = address[ADDR_SEL_BIT];
        in_enable = (address <= ENABLE_TOP) && !sel_bit;
        in_bank   = (address >= BANK_LOW) && (address <= BANK_TOP) && sel_bit;
        in_win    = (address >= WINDOW_BASE) && (address <= WINDOW_TOP);

        dec.enable_wr = is_wr && in_enable;
        dec.bank_wr   = is_wr && !in_enable && in_bank;
        dec.win_wr    = is_wr && !in_enable && !in_bank && in_win;
        dec.win_rd    = !is_wr && in_win;
        dec.handled   = dec.enable_wr || dec.bank_wr || dec.win_wr || dec.win_rd;
    end

endmodule

`default_nettype wire

/* rtl/core/cmrb_ram.sv */
// ----------------------------------------------------------------------------
// cmrb_ram
// 512 x 4 nibble RAM, one write and one registered read per cycle, with a
// clearing sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module cmrb_ram (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                we,
    input  wire logic [cmrb_pkg::RAM_AW-1:0]         waddr,
    input  wire logic [cmrb_pkg::NIB_W-1:0]          wdata,
    input  wire logic                                re,
    input  wire logic [cmrb_pkg::RAM_AW-1:0]         raddr,
    output logic      [cmrb_pkg::NIB_W-1:0]          rdata,
    output logic                                     ready
);
    import cmrb_pkg::*;

    logic [NIB_W-1:0]  mem [RAM_DEPTH];
    logic [RAM_AW-1:0] clr_cnt_reg;
    logic [RAM_AW-1:0] clr_cnt_next;
    logic              clearing_reg;
    logic              clearing_next;
    logic [NIB_W-1:0]  rdata_reg;

    logic              mem_we;
    logic [RAM_AW-1:0] mem_waddr;
    logic [NIB_W-1:0]  mem_wdata;

    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == RAM_AW'(RAM_DEPTH - 1))
                clearing_next = 1'b0;
        end
        mem_we    = clearing_reg || we;
        mem_waddr = clearing_reg ? clr_cnt_reg : waddr;
        mem_wdata = clearing_reg ? '0 : wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clearing_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clearing_reg <= clearing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
    assign ready = !clearing_reg;

endmodule

`default_nettype wire

/* rtl/core/cartridge_mapper_ram_bank.sv */
// ----------------------------------------------------------------------------
// cartridge_mapper_ram_bank
// Cartridge bank controller: RAM enable and ROM bank registers plus a
// 512 x 4 nibble RAM window, one bus access per item.
// ----------------------------------------------------------------------------
// After reset the block sweeps its nibble RAM to zero, one entry per cycle,
// and holds in_stall high until the sweep ends. It then takes one item per
// cycle while the output does not stall. The accepting edge loads the middle
// stage and the registered RAM read; the edge on which the middle stage
// advances loads the output stage, where the item's result is offered.
// A stalled output backs up through the single middle stage to in_stall.
`default_nettype none

module cartridge_mapper_ram_bank (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        action,
    input  wire logic [15:0] address,
    input  wire logic [7:0]  write_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             handled,
    output logic [3:0]       read_data,
    output logic [3:0]       rom_bank,
    output logic             bank_written
);
    import cmrb_pkg::*;

    decode_t           dec;
    logic              in_acc;
    logic              advance;
    logic              ram_ready;
    logic              ram_on;
    logic [NIB_W-1:0]  ram_rdata;
    logic [NIB_W-1:0]  bank_next;

    logic [7:0]        enable_reg;
    logic [NIB_W-1:0]  bank_reg;

    logic              p1_valid_reg;
    logic              p1_handled_reg;
    logic              p1_rd_en_reg;
    logic [NIB_W-1:0]  p1_bank_reg;
    logic              p1_bw_reg;

    logic              out_valid_reg;
    logic              out_handled_reg;
    logic [NIB_W-1:0]  out_rdata_reg;
    logic [NIB_W-1:0]  out_bank_reg;
    logic              out_bw_reg;

    cmrb_decode u_decode (
        .action  (action),
        .address (address),
        .dec     (dec)
    );

    cmrb_ram u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (in_acc && dec.win_wr && ram_on),
        .waddr (address[RAM_AW-1:0]),
        .wdata (write_data[NIB_W-1:0]),
        .re    (in_acc),
        .raddr (address[RAM_AW-1:0]),
        .rdata (ram_rdata),
        .ready (ram_ready)
    );

    always_comb
    begin
        ram_on    = ((enable_reg & ENABLE_MASK) == ENABLE_MASK);
        advance   = p1_valid_reg && (!out_valid_reg || !out_stall);
        in_stall  = !ram_ready || (p1_valid_reg && !advance);
        in_acc    = in_valid && !in_stall;
        bank_next = dec.bank_wr ? write_data[NIB_W-1:0] : bank_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= '0;
            bank_reg      <= BANK_RESET;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                if (dec.enable_wr)
                    enable_reg <= write_data;
                bank_reg <= bank_next;
            end
            if (in_acc)
                p1_valid_reg <= 1'b1;
            else if (advance)
                p1_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            p1_handled_reg <= dec.handled;
            p1_rd_en_reg   <= dec.win_rd && ram_on;
            p1_bank_reg    <= bank_next;
            p1_bw_reg      <= dec.bank_wr;
        end
        if (advance)
        begin
            out_handled_reg <= p1_handled_reg;
            out_rdata_reg   <= p1_rd_en_reg ? ram_rdata : '0;
            out_bank_reg    <= p1_bank_reg;
            out_bw_reg      <= p1_bw_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign handled      = out_handled_reg;
    assign read_data    = out_rdata_reg;
    assign rom_bank     = out_bank_reg;
    assign bank_written = out_bw_reg;

endmodule

`default_nettype wire
